### design/lph_pkg.sv
`default_nettype none
package lph_pkg;

	// Table geometry and field widths
	localparam int TABLE_SIZE = 10;
	localparam int VALUE_W    = 34;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 6;
	localparam int CMP_W      = 7;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	// Remainder unit: value padded to whole bytes, one byte per cycle
	localparam int PAD_W      = ((VALUE_W + 7) / 8) * 8;
	localparam int MOD_STEPS  = PAD_W / 8;
	localparam int STEP_W     = $clog2(MOD_STEPS);

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;

	// Request codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Source of the reported slot
	typedef enum logic [1:0] {
		SLOT_ZERO,
		SLOT_IDX,
		SLOT_HOME
	} slot_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic                load;
		logic                mod_step;
		logic                probe_init;
		logic                advance;
		logic                latch_occ;
		logic                wr;
		logic                wr_occ;
		logic                wr_home;
		logic                emit;
		logic [STATUS_W-1:0] emit_status;
		slot_src_t           slot_src;
		logic                emit_cmp;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic op;
		logic is_zero;
		logic mod_last;
		logic rd_empty;
		logic rd_hit;
		logic occ_home_here;
		logic last_probe;
	} dp_sts_t;

	// Fold eight more bits into a running remainder mod TABLE_SIZE
	function automatic logic [IDX_W-1:0] mod_byte(input logic [IDX_W-1:0] r_in,
		input logic [7:0] b);
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] r;
		r = r_in;
		for (int k = 7; k >= 0; k--) begin
			t = {r, b[k]};
			if (t >= (IDX_W+1)'(TABLE_SIZE)) begin
				t = t - (IDX_W+1)'(TABLE_SIZE);
			end
			r = t[IDX_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/linear_probe_hash_with_replace.sv
`default_nettype none
// Channel   Direction  Handshake         Word
// request   in         start & !busy     op, value
// result    out        done (one cycle)  status, slot, compares
//
// The home slot is computed eight bits per cycle, then the table is probed
// one slot per cycle. A zero value is answered without probing; a search
// sweeps at most all ten slots, as does an insert rejected as full, and an
// insert that displaces an occupant takes one more write to move it. busy
// falls with done.
// arst_n clears the control state and marks every slot empty.
// The receiver cannot stall: each result is shown for exactly one cycle.
module linear_probe_hash_with_replace (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [lph_pkg::VALUE_W-1:0]   value,
	output logic                               done,
	output logic [lph_pkg::STATUS_W-1:0]       status,
	output logic [lph_pkg::SLOT_W-1:0]         slot,
	output logic [lph_pkg::CMP_W-1:0]          compares
);
	import lph_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	lph_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Remainder unit, slot table and result registers
	lph_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.op       (op),
		.value    (value),
		.sts      (sts),
		.done     (done),
		.status   (status),
		.slot     (slot),
		.compares (compares)
	);

endmodule
`default_nettype wire

### design/lph_ctrl.sv
`default_nettype none
module lph_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire lph_pkg::dp_sts_t sts,
	output lph_pkg::dp_cmd_t      cmd,
	output logic                  busy
);
	import lph_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_HOME = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_MOVE = 3'd5;
	localparam logic [2:0] S_SRCH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_zero) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_ZERO;
					cmd.slot_src    = SLOT_ZERO;
					state_nxt       = S_IDLE;
				end else begin
					cmd.probe_init = 1'b1;
					state_nxt      = (sts.op == OP_SEARCH) ? S_SRCH : S_HOME;
				end
			end
			S_HOME: begin
				if (sts.rd_empty) begin
					cmd.wr          = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_INSERTED;
					cmd.slot_src    = SLOT_IDX;
					state_nxt       = S_IDLE;
				end else begin
					cmd.latch_occ = 1'b1;
					cmd.advance   = 1'b1;
					state_nxt     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.rd_empty) begin
					cmd.wr = 1'b1;
					if (!sts.occ_home_here) begin
						// displaced occupant goes to the empty slot first
						cmd.wr_occ = 1'b1;
						state_nxt  = S_MOVE;
					end else begin
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_INSERTED;
						cmd.slot_src    = SLOT_IDX;
						state_nxt       = S_IDLE;
					end
				end else if (sts.last_probe) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FULL;
					cmd.slot_src    = SLOT_ZERO;
					state_nxt       = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_MOVE: begin
				cmd.wr          = 1'b1;
				cmd.wr_home     = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_INSERTED;
				cmd.slot_src    = SLOT_HOME;
				state_nxt       = S_IDLE;
			end
			S_SRCH: begin
				if (sts.rd_hit) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FOUND;
					cmd.slot_src    = SLOT_IDX;
					cmd.emit_cmp    = 1'b1;
					state_nxt       = S_IDLE;
				end else if (sts.last_probe) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_NOT_FOUND;
					cmd.slot_src    = SLOT_ZERO;
					cmd.emit_cmp    = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/lph_dp.sv
`default_nettype none
module lph_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lph_pkg::dp_cmd_t              cmd,
	input  wire logic                          op,
	input  wire logic [lph_pkg::VALUE_W-1:0]   value,
	output lph_pkg::dp_sts_t                   sts,
	output logic                               done,
	output logic [lph_pkg::STATUS_W-1:0]       status,
	output logic [lph_pkg::SLOT_W-1:0]         slot,
	output logic [lph_pkg::CMP_W-1:0]          compares
);
	import lph_pkg::*;

	// Request registers
	logic               op_q;
	logic [VALUE_W-1:0] val_q;
	logic [PAD_W-1:0]   sh_q;
	logic [STEP_W-1:0]  step_q;
	logic [IDX_W-1:0]   rem_q;

	// Probe registers
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] occ_val_q;
	logic [IDX_W-1:0]   occ_home_q;

	// Table: value, home slot of the value, valid bit
	logic [VALUE_W-1:0]    tab_val_q [TABLE_SIZE];
	logic [IDX_W-1:0]      tab_home_q [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] tab_vld_q;

	// Result registers
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CMP_W-1:0]    compares_q;

	logic [VALUE_W-1:0] rd_val;
	logic [IDX_W-1:0]   rd_home;
	logic [IDX_W-1:0]   idx_nxt;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_val;
	logic [IDX_W-1:0]   wr_home_tag;

	// Table read at the probe index; an invalid entry reads as empty
	assign rd_val  = tab_vld_q[idx_q] ? tab_val_q[idx_q] : '0;
	assign rd_home = tab_home_q[idx_q];

	assign idx_nxt = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;

	// Write port: new word at probe index or home, or moved occupant
	assign wr_addr     = cmd.wr_home ? rem_q : idx_q;
	assign wr_val      = cmd.wr_occ ? occ_val_q : val_q;
	assign wr_home_tag = cmd.wr_occ ? occ_home_q : rem_q;

	// Status back to the controller
	assign sts.op            = op_q;
	assign sts.is_zero       = (val_q == '0);
	assign sts.mod_last      = (step_q == STEP_W'(MOD_STEPS - 1));
	assign sts.rd_empty      = (rd_val == '0);
	assign sts.rd_hit        = (rd_val == val_q);
	assign sts.occ_home_here = (occ_home_q == rem_q);
	assign sts.last_probe    = (cnt_q == CNT_W'(TABLE_SIZE));

	// Request capture and remainder, one byte per cycle from the top
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			val_q  <= value;
			sh_q   <= PAD_W'(value);
			step_q <= '0;
			rem_q  <= '0;
		end else if (cmd.mod_step) begin
			rem_q  <= mod_byte(rem_q, sh_q[PAD_W-1 -: 8]);
			sh_q   <= sh_q << 8;
			step_q <= step_q + 1'b1;
		end
	end

	// Probe index and slots-compared count
	always_ff @(posedge clk) begin
		if (cmd.probe_init) begin
			idx_q <= rem_q;
			cnt_q <= CNT_W'(1);
		end else if (cmd.advance) begin
			idx_q <= idx_nxt;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Occupant of the home slot
	always_ff @(posedge clk) begin
		if (cmd.latch_occ) begin
			occ_val_q  <= rd_val;
			occ_home_q <= rd_home;
		end
	end

	// Table words
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			tab_val_q[wr_addr]  <= wr_val;
			tab_home_q[wr_addr] <= wr_home_tag;
		end
	end

	// Valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_vld_q <= '0;
		end else if (cmd.wr) begin
			tab_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			case (cmd.slot_src)
				SLOT_IDX:  slot_q <= SLOT_W'(idx_q);
				SLOT_HOME: slot_q <= SLOT_W'(rem_q);
				default:   slot_q <= '0;
			endcase
			compares_q <= cmd.emit_cmp ? CMP_W'(cnt_q) : '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign slot     = slot_q;
	assign compares = compares_q;

endmodule
`default_nettype wire

### dv/tb_linear_probe_hash_with_replace.sv
module tb_linear_probe_hash_with_replace;
	timeunit 1ns;
	timeprecision 1ps;

	import lph_pkg::*;

	// Cycles with no word moving on either side before the run is abandoned
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_WORDS = 1930;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [CMP_W-1:0]    compares;
	} hash_word_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic                op       = OP_INSERT;
	logic [VALUE_W-1:0]  value    = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [CMP_W-1:0]    compares;

	// Shadow copy of the table and the answers still owed by the block
	logic [VALUE_W-1:0]  shadow_slots [TABLE_SIZE];
	hash_word_t          pending_answers [$];

	int errors      = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	int n_words     = 0;
	int n_inserts   = 0;
	int n_full      = 0;
	int n_searches  = 0;
	int n_hits      = 0;
	int n_zero      = 0;

	linear_probe_hash_with_replace uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.value    (value),
		.done     (done),
		.status   (status),
		.slot     (slot),
		.compares (compares)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Insert or search against the shadow table, giving the answer expected
	task automatic hash_lookup(input logic o, input logic [VALUE_W-1:0] v,
		output hash_word_t w);
		int                 home;
		int                 spot;
		int                 i;
		int                 n;
		logic [VALUE_W-1:0] occ;
		w = '{ST_ZERO, '0, '0};
		if (v != '0) begin
			home = int'(v % TABLE_SIZE);
			if (o == OP_INSERT) begin
				occ = shadow_slots[home];
				if (occ == '0) begin
					shadow_slots[home] = v;
					w = '{ST_INSERTED, SLOT_W'(home), '0};
				end else begin
					// first empty slot after home, wrapping
					spot = -1;
					for (n = 1; n < TABLE_SIZE; n++) begin
						i = (home + n) % TABLE_SIZE;
						if (spot < 0 && shadow_slots[i] == '0) spot = i;
					end
					if (spot < 0) begin
						w = '{ST_FULL, '0, '0};
					end else if (int'(occ % TABLE_SIZE) != home) begin
						// occupant is a guest here: new value takes home, guest moves on
						shadow_slots[home] = v;
						shadow_slots[spot] = occ;
						w = '{ST_INSERTED, SLOT_W'(home), '0};
					end else begin
						shadow_slots[spot] = v;
						w = '{ST_INSERTED, SLOT_W'(spot), '0};
					end
				end
			end else begin
				w = '{ST_NOT_FOUND, '0, CMP_W'(TABLE_SIZE)};
				for (n = 0; n < TABLE_SIZE; n++) begin
					i = (home + n) % TABLE_SIZE;
					if (shadow_slots[i] == v) begin
						w = '{ST_FOUND, SLOT_W'(i), CMP_W'(n + 1)};
						break;
					end
				end
			end
		end
	endtask

	// Send one word; bursts of random length with random gaps in between
	task automatic issue_word(input logic o, input logic [VALUE_W-1:0] v);
		int         gap;
		hash_word_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		op    <= o;
		value <= v;
		do @(posedge clk); while (busy);
		hash_lookup(o, v, w);
		pending_answers.push_back(w);
		n_words++;
		if (v == '0) n_zero++;
		else if (o == OP_INSERT) begin
			n_inserts++;
			if (w.status == ST_FULL) n_full++;
		end else begin
			n_searches++;
			if (w.status == ST_FOUND) n_hits++;
		end
	endtask

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// Compare each result with the oldest answer owed
	always @(posedge clk) begin
		hash_word_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report($sformatf("result with nothing pending (status %0d slot %0d cmp %0d)",
					status, slot, compares));
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status)
					report($sformatf("status %0d, want %0d", status, want.status));
				if (slot !== want.slot)
					report($sformatf("slot %0d, want %0d", slot, want.slot));
				if (compares !== want.compares)
					report($sformatf("compares %0d, want %0d", compares, want.compares));
			end
		end
	end

	// Watchdog on cycles where no word moves
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Zero is never stored, under either op
	task automatic test_zero_value();
		issue_word(OP_INSERT, '0);
		issue_word(OP_SEARCH, '0);
	endtask

	// Miss on an empty table sweeps every slot
	task automatic test_empty_search();
		issue_word(OP_SEARCH, VALUE_W'(5));
	endtask

	// Collision at the last slot wraps to slot 0, then gets displaced
	task automatic test_wraparound();
		issue_word(OP_INSERT, VALUE_W'(9));
		issue_word(OP_INSERT, VALUE_W'(19));
		issue_word(OP_SEARCH, VALUE_W'(19));
		issue_word(OP_INSERT, VALUE_W'(10));
		issue_word(OP_SEARCH, VALUE_W'(19));
	endtask

	// Guests pushed out of their slots, same-home chaining, duplicates, extremes
	task automatic test_displacement();
		issue_word(OP_INSERT, VALUE_W'(1));
		issue_word(OP_INSERT, VALUE_W'(11));
		issue_word(OP_INSERT, VALUE_W'(2));
		issue_word(OP_INSERT, '1);
		issue_word(OP_INSERT, VALUE_W'(64'd9999999999));
		issue_word(OP_INSERT, VALUE_W'(1));
		issue_word(OP_INSERT, VALUE_W'(12345678));
	endtask

	// Table is now full: insert is rejected, searches still work
	task automatic test_full_table();
		issue_word(OP_INSERT, VALUE_W'(3));
		issue_word(OP_SEARCH, VALUE_W'(11));
		issue_word(OP_SEARCH, VALUE_W'(7));
		issue_word(OP_SEARCH, '1);
	endtask

	// Mixed traffic: mostly searches, for stored values, near misses and random values
	task automatic test_random_traffic();
		int                 pick;
		logic [VALUE_W-1:0] v;
		repeat (RANDOM_WORDS) begin
			pick = $urandom_range(99, 0);
			v = {2'($urandom_range(3, 0)), 32'($urandom())};
			if (pick < 10) begin
				issue_word(1'($urandom_range(1, 0)), '0);
			end else if (pick < 35) begin
				issue_word(OP_INSERT, v);
			end else if (pick < 65) begin
				issue_word(OP_SEARCH, shadow_slots[$urandom_range(TABLE_SIZE - 1, 0)]);
			end else if (pick < 80) begin
				// same home as a stored value, usually absent
				v = shadow_slots[$urandom_range(TABLE_SIZE - 1, 0)];
				issue_word(OP_SEARCH, v + VALUE_W'(TABLE_SIZE * $urandom_range(3, 1)));
			end else begin
				issue_word(OP_SEARCH, v);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) shadow_slots[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_value();
		test_empty_search();
		test_wraparound();
		test_displacement();
		test_full_table();
		test_random_traffic();

		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d words: %0d inserts (%0d rejected full), %0d searches (%0d hits),",
			n_words, n_inserts, n_full, n_searches, n_hits);
		$display("%0d zero values; %0d mismatches seen.", n_zero, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
